@@ rtl/encoder_set_countdown_timer_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef ENCODER_SET_COUNTDOWN_TIMER_UNIT_DEFINES_SVH
`define ENCODER_SET_COUNTDOWN_TIMER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/est_pkg.sv @@
package est_pkg;

  localparam int SEC_W  = 13;
  localparam int STEP_W = 10;
  localparam int MS_W   = 16;
  localparam int TIME_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] MODE_STOPPED  = 2'd0;
  localparam logic [1:0] MODE_RUNNING  = 2'd1;
  localparam logic [1:0] MODE_FINISHED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_HOLD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_HOLD    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEN  = 3'd6;

  localparam logic [STEP_W-1:0] STEP_RESET       = 10'd10;
  localparam logic [SEC_W-1:0]  MIN_RESET        = 13'd0;
  localparam logic [SEC_W-1:0]  MAX_RESET        = 13'd5999;
  localparam logic [SEC_W-1:0]  DEFAULT_RESET    = 13'd60;
  localparam logic [MS_W-1:0]   ENC_HOLD_RESET   = 16'd20;
  localparam logic [MS_W-1:0]   BTN_HOLD_RESET   = 16'd200;
  localparam logic [MS_W-1:0]   SECOND_LEN_RESET = 16'd1000;

  typedef struct packed {
    logic enc_a;
    logic enc_b;
    logic button_level;
  } sample_t;

  typedef struct packed {
    logic [1:0]       run_state;
    logic [SEC_W-1:0] set_seconds;
    logic [SEC_W-1:0] remaining_seconds;
    logic [SEC_W-1:0] shown_seconds;
    logic             changed;
  } result_t;

endpackage

@@ rtl/est_in_stage.sv @@
module est_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  est_pkg::sample_t in_sample,
  input  logic             down_ready,
  output logic             fire,
  output est_pkg::sample_t sample
);

  logic             vld_r;
  est_pkg::sample_t sample_r;

  assign fire     = vld_r && down_ready;
  assign in_stall = vld_r && !down_ready;
  assign sample   = sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      vld_r <= 1'b1;
    end else if (fire) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      sample_r <= in_sample;
    end
  end

endmodule

@@ rtl/est_out_stage.sv @@
module est_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  est_pkg::result_t result,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output est_pkg::result_t out_result
);

  logic             vld_r;
  est_pkg::result_t result_r;

  assign ready      = !vld_r || !out_stall;
  assign out_valid  = vld_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready) begin
      vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result;
    end
  end

endmodule

@@ rtl/est_core.sv @@
module est_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [est_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [est_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                fire,
  input  est_pkg::sample_t                    sample,
  output est_pkg::result_t                    result
);

  localparam int SEC_W  = est_pkg::SEC_W;
  localparam int MS_W   = est_pkg::MS_W;
  localparam int TIME_W = est_pkg::TIME_W;
  localparam int SUM_W  = SEC_W + 2;

  // configuration
  logic [est_pkg::STEP_W-1:0] step_r;
  logic [SEC_W-1:0]           min_r;
  logic [SEC_W-1:0]           max_r;
  logic [MS_W-1:0]            enc_hold_r;
  logic [MS_W-1:0]            btn_hold_r;
  logic [MS_W-1:0]            second_len_r;

  // timer state
  logic [TIME_W-1:0] now_r;
  logic              enc_prev_a_r;
  logic [TIME_W-1:0] enc_edge_time_r;
  logic              btn_prev_r;
  logic [TIME_W-1:0] btn_press_time_r;
  logic [SEC_W-1:0]  set_time_r;
  logic [SEC_W-1:0]  remaining_r;
  logic [1:0]        mode_r;
  logic [TIME_W-1:0] second_mark_r;

  logic [TIME_W-1:0] enc_since;
  logic              enc_take;
  logic              enc_step;
  logic [SUM_W-1:0]  set_ext;
  logic [SUM_W-1:0]  step_ext;
  logic [SUM_W-1:0]  sum;
  logic [SEC_W-1:0]  clamped;
  logic [SEC_W-1:0]  set_a;
  logic [SEC_W-1:0]  rem_a;

  logic [TIME_W-1:0] btn_since;
  logic              btn_open;
  logic              press;
  logic              btn_prev_nxt;

  logic [1:0]        mode_b;
  logic [SEC_W-1:0]  rem_b;
  logic              press_chg;
  logic              start;

  logic [TIME_W-1:0] run_since;
  logic              tick;
  logic              dec;
  logic [SEC_W-1:0]  rem_c;
  logic [1:0]        mode_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= est_pkg::STEP_RESET;
      min_r        <= est_pkg::MIN_RESET;
      max_r        <= est_pkg::MAX_RESET;
      enc_hold_r   <= est_pkg::ENC_HOLD_RESET;
      btn_hold_r   <= est_pkg::BTN_HOLD_RESET;
      second_len_r <= est_pkg::SECOND_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        est_pkg::CFG_STEP:       step_r       <= cfg_wdata[est_pkg::STEP_W-1:0];
        est_pkg::CFG_MIN:        min_r        <= cfg_wdata[SEC_W-1:0];
        est_pkg::CFG_MAX:        max_r        <= cfg_wdata[SEC_W-1:0];
        // reset reloads the default as well, so a written default never shows
        est_pkg::CFG_DEFAULT:    ;
        est_pkg::CFG_ENC_HOLD:   enc_hold_r   <= cfg_wdata;
        est_pkg::CFG_BTN_HOLD:   btn_hold_r   <= cfg_wdata;
        est_pkg::CFG_SECOND_LEN: second_len_r <= cfg_wdata;
        default:                 ;
      endcase
    end
  end

  // encoder, decoded only while stopped
  always_comb begin
    enc_since = now_r - enc_edge_time_r;
    enc_take  = (mode_r == est_pkg::MODE_STOPPED) &&
                (enc_since >= {{(TIME_W-MS_W){1'b0}}, enc_hold_r}) &&
                (sample.enc_a != enc_prev_a_r);
    enc_step  = enc_take && sample.enc_a;
    set_ext   = {2'b00, set_time_r};
    step_ext  = {{(SUM_W-est_pkg::STEP_W){1'b0}}, step_r};
    sum       = sample.enc_b ? (set_ext + step_ext) : (set_ext - step_ext);
    if ($signed(sum) < $signed({2'b00, min_r})) begin
      clamped = min_r;
    end else if ($signed(sum) > $signed({2'b00, max_r})) begin
      clamped = max_r;
    end else begin
      clamped = sum[SEC_W-1:0];
    end
    set_a = enc_step ? clamped : set_time_r;
    rem_a = enc_step ? clamped : remaining_r;
  end

  // button debounce
  always_comb begin
    btn_since = now_r - btn_press_time_r;
    btn_open  = btn_since >= {{(TIME_W-MS_W){1'b0}}, btn_hold_r};
    press     = btn_open && sample.button_level && !btn_prev_r;
    if (press) begin
      btn_prev_nxt = 1'b1;
    end else if (btn_since > {{(TIME_W-MS_W){1'b0}}, btn_hold_r}) begin
      btn_prev_nxt = sample.button_level;
    end else begin
      btn_prev_nxt = btn_prev_r;
    end
  end

  // press action
  always_comb begin
    mode_b    = mode_r;
    rem_b     = rem_a;
    press_chg = 1'b0;
    start     = 1'b0;
    if (press) begin
      unique case (mode_r) inside
        est_pkg::MODE_STOPPED: begin
          mode_b    = est_pkg::MODE_RUNNING;
          rem_b     = set_a;
          press_chg = 1'b1;
          start     = 1'b1;
        end
        est_pkg::MODE_RUNNING, est_pkg::MODE_FINISHED: begin
          mode_b    = est_pkg::MODE_STOPPED;
          rem_b     = set_a;
          press_chg = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // countdown; a start in this sample marks the second at now
  always_comb begin
    run_since = start ? '0 : (now_r - second_mark_r);
    tick      = (mode_b == est_pkg::MODE_RUNNING) &&
                (run_since >= {{(TIME_W-MS_W){1'b0}}, second_len_r});
    dec       = tick && (rem_b != '0);
    rem_c     = dec ? (rem_b - SEC_W'(1)) : rem_b;
    mode_c    = (dec && (rem_c == '0)) ? est_pkg::MODE_FINISHED : mode_b;
  end

  always_comb begin
    result.run_state         = mode_c;
    result.set_seconds       = set_a;
    result.remaining_seconds = rem_c;
    result.shown_seconds     = (mode_c == est_pkg::MODE_STOPPED) ? set_a : rem_c;
    result.changed           = enc_step || press_chg || dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r            <= '0;
      enc_prev_a_r     <= 1'b1;
      enc_edge_time_r  <= '0;
      btn_prev_r       <= 1'b0;
      btn_press_time_r <= '0;
      set_time_r       <= est_pkg::DEFAULT_RESET;
      remaining_r      <= est_pkg::DEFAULT_RESET;
      mode_r           <= est_pkg::MODE_STOPPED;
      second_mark_r    <= '0;
    end else if (fire) begin
      now_r <= now_r + TIME_W'(1);
      if (enc_take) begin
        enc_prev_a_r    <= sample.enc_a;
        enc_edge_time_r <= now_r;
      end
      btn_prev_r <= btn_prev_nxt;
      if (press) begin
        btn_press_time_r <= now_r;
      end
      set_time_r  <= set_a;
      remaining_r <= rem_c;
      mode_r      <= mode_c;
      if (start || tick) begin
        second_mark_r <= now_r;
      end
    end
  end

endmodule

@@ rtl/encoder_set_countdown_timer_unit.sv @@
// Channel  Handshake            Word
// in       in_valid / in_stall  in_enc_a, in_enc_b, in_button_level
// out      out_valid/out_stall  out_run_state, out_set_seconds, out_remaining_seconds,
//                               out_shown_seconds, out_changed
// cfg      cfg_we               cfg_index, cfg_wdata
//
// One word in per cycle while in_stall is low, one result per word; an accepted word passes
// through the input register and then the result register before out_valid. The timer logic
// between them updates state and loads the result register together, on the same fire.
// rst_n (synchronous) loads the register defaults and a set time of 60 s.
// A stalled result holds the pipe; the input register still takes a word while
// it is empty or the result register is free or being drained.
module encoder_set_countdown_timer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_enc_a,
  input  logic                           in_enc_b,
  input  logic                           in_button_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_run_state,
  output logic [est_pkg::SEC_W-1:0]      out_set_seconds,
  output logic [est_pkg::SEC_W-1:0]      out_remaining_seconds,
  output logic [est_pkg::SEC_W-1:0]      out_shown_seconds,
  output logic                           out_changed,
  input  logic                           cfg_we,
  input  logic [est_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [est_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  est_pkg::sample_t in_sample;
  est_pkg::sample_t sample;
  est_pkg::result_t result;
  est_pkg::result_t out_result;
  logic             fire;
  logic             down_ready;

  assign in_sample.enc_a        = in_enc_a;
  assign in_sample.enc_b        = in_enc_b;
  assign in_sample.button_level = in_button_level;

  est_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .down_ready (down_ready),
    .fire       (fire),
    .sample     (sample)
  );

  est_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .sample    (sample),
    .result    (result)
  );

  est_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .result     (result),
    .ready      (down_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_run_state         = out_result.run_state;
  assign out_set_seconds       = out_result.set_seconds;
  assign out_remaining_seconds = out_result.remaining_seconds;
  assign out_shown_seconds     = out_result.shown_seconds;
  assign out_changed           = out_result.changed;

endmodule

@@ rtl/est_checker.sv @@
`include "encoder_set_countdown_timer_unit_defines.svh"

module est_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                out_run_state,
  input logic [est_pkg::SEC_W-1:0] out_set_seconds,
  input logic [est_pkg::SEC_W-1:0] out_remaining_seconds,
  input logic [est_pkg::SEC_W-1:0] out_shown_seconds,
  input logic                      out_changed
);

  // hold a stalled word
  `EST_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_run_state) && $stable(out_set_seconds) &&
    $stable(out_remaining_seconds) && $stable(out_shown_seconds) && $stable(out_changed),
    "stalled result word changed")
  `EST_ASSERT_NOW(a_shown_set, out_valid && (out_run_state == est_pkg::MODE_STOPPED),
    out_shown_seconds == out_set_seconds, "stopped timer must show set time")
  `EST_ASSERT_NOW(a_shown_rem, out_valid && (out_run_state != est_pkg::MODE_STOPPED),
    out_shown_seconds == out_remaining_seconds, "active timer must show remaining time")
  `EST_ASSERT_NOW(a_finished_zero, out_valid && (out_run_state == est_pkg::MODE_FINISHED),
    out_remaining_seconds == '0, "finished timer with time left")

endmodule

bind encoder_set_countdown_timer_unit est_checker u_est_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_run_state         (out_run_state),
  .out_set_seconds       (out_set_seconds),
  .out_remaining_seconds (out_remaining_seconds),
  .out_shown_seconds     (out_shown_seconds),
  .out_changed           (out_changed)
);

@@ tb/encoder_set_countdown_timer_unit_tb.sv @@
`timescale 1ns / 100ps

module encoder_set_countdown_timer_unit_tb;

  localparam int SEC_W      = est_pkg::SEC_W;
  localparam int STEP_W     = est_pkg::STEP_W;
  localparam int MS_W       = est_pkg::MS_W;
  localparam int TIME_W     = est_pkg::TIME_W;
  localparam int CFG_IDX_W  = est_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = est_pkg::CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    est_pkg::sample_t      s;
    bit                    pinned;
    est_pkg::result_t      want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_enc_a;
  logic                  in_enc_b;
  logic                  in_button_level;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_run_state;
  logic [SEC_W-1:0]      out_set_seconds;
  logic [SEC_W-1:0]      out_remaining_seconds;
  logic [SEC_W-1:0]      out_shown_seconds;
  logic                  out_changed;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // timer registers as the testbench tracks them
  logic [STEP_W-1:0] step_s;
  logic [SEC_W-1:0]  floor_s;
  logic [SEC_W-1:0]  ceil_s;
  logic [SEC_W-1:0]  dflt_s;
  logic [MS_W-1:0]   enc_hold;
  logic [MS_W-1:0]   btn_hold;
  logic [MS_W-1:0]   tick_len;

  // timer state as the testbench tracks it
  logic [TIME_W-1:0] clk_ms;
  logic              a_last;
  logic [TIME_W-1:0] a_edge_ms;
  logic              btn_q;
  logic [TIME_W-1:0] btn_press_ms;
  logic [SEC_W-1:0]  set_sec;
  logic [SEC_W-1:0]  left_sec;
  logic [1:0]        run_mode;
  logic [TIME_W-1:0] tick_ms;

  est_pkg::result_t pending_results[$];
  script_row_t      script[$];

  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int change_words = 0;
  int finished_words = 0;
  int gap_cap = 18;
  int stall_cap = 18;

  encoder_set_countdown_timer_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_enc_a              (in_enc_a),
    .in_enc_b              (in_enc_b),
    .in_button_level       (in_button_level),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_run_state         (out_run_state),
    .out_set_seconds       (out_set_seconds),
    .out_remaining_seconds (out_remaining_seconds),
    .out_shown_seconds     (out_shown_seconds),
    .out_changed           (out_changed),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One millisecond of the timer: encoder, then button, then countdown.
  function automatic est_pkg::result_t advance_timer(est_pkg::sample_t s);
    logic              chg;
    int                t;
    logic [TIME_W-1:0] since;
    est_pkg::result_t  r;
    chg = 1'b0;
    if (run_mode == est_pkg::MODE_STOPPED && (clk_ms - a_edge_ms) >= TIME_W'(enc_hold) &&
        s.enc_a != a_last) begin
      a_edge_ms = clk_ms;
      a_last = s.enc_a;
      if (s.enc_a) begin
        t = s.enc_b ? int'(set_sec) + int'(step_s) : int'(set_sec) - int'(step_s);
        // raise to the floor first; lower to the ceiling only if not below the floor
        if (t < int'(floor_s))
          t = int'(floor_s);
        else if (t > int'(ceil_s))
          t = int'(ceil_s);
        set_sec = t[SEC_W-1:0];
        left_sec = set_sec;
        chg = 1'b1;
      end
    end
    since = clk_ms - btn_press_ms;
    if (since >= TIME_W'(btn_hold)) begin
      if (s.button_level && !btn_q) begin
        btn_q = 1'b1;
        btn_press_ms = clk_ms;
        if (run_mode == est_pkg::MODE_STOPPED) begin
          run_mode = est_pkg::MODE_RUNNING;
          left_sec = set_sec;
          tick_ms = clk_ms;
          chg = 1'b1;
        end else if (run_mode == est_pkg::MODE_RUNNING ||
                     run_mode == est_pkg::MODE_FINISHED) begin
          run_mode = est_pkg::MODE_STOPPED;
          left_sec = set_sec;
          chg = 1'b1;
        end
      end else if (since > TIME_W'(btn_hold)) begin
        btn_q = s.button_level;
      end
    end
    if (run_mode == est_pkg::MODE_RUNNING && (clk_ms - tick_ms) >= TIME_W'(tick_len)) begin
      tick_ms = clk_ms;
      // a countdown at zero keeps running and ticks without counting down
      if (left_sec != '0) begin
        left_sec = left_sec - SEC_W'(1);
        if (left_sec == '0)
          run_mode = est_pkg::MODE_FINISHED;
        chg = 1'b1;
      end
    end
    r.run_state = run_mode;
    r.set_seconds = set_sec;
    r.remaining_seconds = left_sec;
    r.shown_seconds = (run_mode == est_pkg::MODE_STOPPED) ? set_sec : left_sec;
    r.changed = chg;
    clk_ms = clk_ms + TIME_W'(1);
    return r;
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    script_row_t row;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.value = v;
    row.s = '0;
    row.pinned = 1'b0;
    row.want = '0;
    script.push_back(row);
  endfunction

  function automatic void add_sample(logic a, logic b, logic btn);
    script_row_t row;
    row.kind = ROW_SAMPLE;
    row.idx = est_pkg::CFG_STEP;
    row.value = '0;
    row.s = '{enc_a: a, enc_b: b, button_level: btn};
    row.pinned = 1'b0;
    row.want = '0;
    script.push_back(row);
  endfunction

  function automatic void add_checked(logic a, logic b, logic btn, logic [1:0] st,
                                      logic [SEC_W-1:0] set_v, logic [SEC_W-1:0] rem_v,
                                      logic [SEC_W-1:0] shown_v, logic chg);
    script_row_t row;
    row.kind = ROW_SAMPLE;
    row.idx = est_pkg::CFG_STEP;
    row.value = '0;
    row.s = '{enc_a: a, enc_b: b, button_level: btn};
    row.pinned = 1'b1;
    row.want = '{run_state: st, set_seconds: set_v, remaining_seconds: rem_v,
                 shown_seconds: shown_v, changed: chg};
    script.push_back(row);
  endfunction

  function automatic void compare_field(string name, logic [SEC_W-1:0] want_v,
                                        logic [SEC_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      est_pkg::CFG_STEP:       step_s = v[STEP_W-1:0];
      est_pkg::CFG_MIN:        floor_s = v[SEC_W-1:0];
      est_pkg::CFG_MAX:        ceil_s = v[SEC_W-1:0];
      est_pkg::CFG_DEFAULT:    dflt_s = v[SEC_W-1:0];
      est_pkg::CFG_ENC_HOLD:   enc_hold = v;
      est_pkg::CFG_BTN_HOLD:   btn_hold = v;
      est_pkg::CFG_SECOND_LEN: tick_len = v;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input est_pkg::sample_t s, input bit pinned,
                             input est_pkg::result_t want);
    int               gap;
    est_pkg::result_t predicted;
    gap = $urandom_range(0, gap_cap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_enc_a <= s.enc_a;
    in_enc_b <= s.enc_b;
    in_button_level <= s.button_level;
    do @(posedge clk); while (in_stall);
    predicted = advance_timer(s);
    pending_results.push_back(pinned ? want : predicted);
    samples_sent++;
    if (predicted.changed)
      change_words++;
    if (predicted.run_state == est_pkg::MODE_FINISHED)
      finished_words++;
  endtask

  // Drop valid, wait out every pending result, then the pipe's own latency.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic pick_settings(input int phase);
    int step_v, lo, hi, eh, bh, sl;
    step_v = $urandom_range(1, 600);
    lo = $urandom_range(0, 5);
    hi = lo + $urandom_range(0, 700);
    eh = $urandom_range(0, 6);
    bh = $urandom_range(0, 10);
    sl = $urandom_range(0, 15);
    case (phase)
      0: begin
        step_v = 600; lo = 0; hi = 5999; eh = 0; bh = 0; sl = 1;
      end
      1: begin
        step_v = 1; lo = 5999; hi = 0; eh = 1; bh = 1; sl = 0;
      end
      2: begin
        lo = 0; hi = 5999; eh = 65535; bh = 65535; sl = 65535;
      end
      default: begin
        if ($urandom_range(0, 5) == 0) begin
          lo = $urandom_range(100, 5999);
          hi = $urandom_range(0, 99);
        end
      end
    endcase
    write_reg(est_pkg::CFG_STEP, CFG_DATA_W'(step_v));
    write_reg(est_pkg::CFG_MIN, CFG_DATA_W'(lo));
    write_reg(est_pkg::CFG_MAX, CFG_DATA_W'(hi));
    write_reg(est_pkg::CFG_ENC_HOLD, CFG_DATA_W'(eh));
    write_reg(est_pkg::CFG_BTN_HOLD, CFG_DATA_W'(bh));
    write_reg(est_pkg::CFG_SECOND_LEN, CFG_DATA_W'(sl));
    write_reg(est_pkg::CFG_DEFAULT,
              (phase == 1) ? '0 : CFG_DATA_W'($urandom_range(0, 5999)));
  endtask

  // Mostly detents and button presses with random timing, some raw noise.
  task automatic play_random(input int count);
    int               sent, kind, len, i;
    logic             dir;
    est_pkg::sample_t s;
    sent = 0;
    s = '0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(1, 12);
      dir = 1'($urandom_range(0, 1));
      for (i = 0; i < 2 * len; i++) begin
        if (kind < 6) begin
          // A low then high with B steady; flip A now and then for bounce
          s.enc_a = (i >= len) ^ ($urandom_range(0, 19) == 0);
          s.enc_b = dir;
          s.button_level = 1'b0;
        end else if (kind < 9) begin
          s.button_level = (i < len) ^ ($urandom_range(0, 19) == 0);
          s.enc_b = 1'($urandom_range(0, 1));
        end else begin
          s = est_pkg::sample_t'(3'($urandom_range(0, 7)));
        end
        send_sample(s, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin : drain
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = $urandom_range(0, stall_cap);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : score
    est_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("out: result word with no sample outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("run_state", SEC_W'(want.run_state), SEC_W'(out_run_state));
        compare_field("set_seconds", want.set_seconds, out_set_seconds);
        compare_field("remaining_seconds", want.remaining_seconds,
                      out_remaining_seconds);
        compare_field("shown_seconds", want.shown_seconds, out_shown_seconds);
        compare_field("changed", SEC_W'(want.changed), SEC_W'(out_changed));
      end
    end
  end

  initial begin : run
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_enc_a = 1'b0;
    in_enc_b = 1'b0;
    in_button_level = 1'b0;
    cfg_we = 1'b0;
    cfg_index = est_pkg::CFG_STEP;
    cfg_wdata = '0;

    step_s = est_pkg::STEP_RESET;
    floor_s = est_pkg::MIN_RESET;
    ceil_s = est_pkg::MAX_RESET;
    dflt_s = est_pkg::DEFAULT_RESET;
    enc_hold = est_pkg::ENC_HOLD_RESET;
    btn_hold = est_pkg::BTN_HOLD_RESET;
    tick_len = est_pkg::SECOND_LEN_RESET;
    clk_ms = '0;
    a_last = 1'b1;
    a_edge_ms = '0;
    btn_q = 1'b0;
    btn_press_ms = '0;
    set_sec = est_pkg::DEFAULT_RESET;
    left_sec = est_pkg::DEFAULT_RESET;
    run_mode = est_pkg::MODE_STOPPED;
    tick_ms = '0;

    // early samples: every change falls inside the hold-off after reset
    add_checked(1, 1, 1, est_pkg::MODE_STOPPED, 60, 60, 60, 0);
    add_checked(0, 0, 0, est_pkg::MODE_STOPPED, 60, 60, 60, 0);
    add_write(est_pkg::CFG_STEP, 600);
    add_write(est_pkg::CFG_MIN, 1);
    add_write(est_pkg::CFG_MAX, 1000);
    add_write(est_pkg::CFG_DEFAULT, 5999);
    add_write(est_pkg::CFG_ENC_HOLD, 0);
    add_write(est_pkg::CFG_BTN_HOLD, 0);
    add_write(est_pkg::CFG_SECOND_LEN, 1);
    add_write(CFG_NO_REG, 16'hFFFF);
    add_checked(0, 1, 0, est_pkg::MODE_STOPPED, 60, 60, 60, 0);
    add_checked(1, 1, 0, est_pkg::MODE_STOPPED, 660, 660, 660, 1);
    add_sample(0, 0, 0);
    add_sample(1, 0, 0);
    add_sample(0, 0, 0);
    add_checked(1, 0, 0, est_pkg::MODE_STOPPED, 1, 1, 1, 1);
    add_sample(0, 0, 0);
    add_sample(1, 0, 0);
    add_sample(0, 0, 1);
    add_checked(0, 0, 0, est_pkg::MODE_FINISHED, 1, 0, 0, 1);
    add_sample(1, 1, 0);
    add_sample(0, 0, 1);
    add_sample(1, 1, 0);
    add_sample(0, 1, 0);
    add_checked(1, 1, 0, est_pkg::MODE_STOPPED, 1000, 1000, 1000, 1);
    add_sample(0, 1, 1);
    add_sample(1, 0, 0);
    add_sample(0, 0, 1);
    // floor above ceiling, one-second ticks on every sample
    add_write(est_pkg::CFG_STEP, 1);
    add_write(est_pkg::CFG_MIN, 5999);
    add_write(est_pkg::CFG_MAX, 0);
    add_write(est_pkg::CFG_SECOND_LEN, 0);
    add_checked(1, 1, 0, est_pkg::MODE_STOPPED, 5999, 5999, 5999, 1);
    add_sample(0, 1, 0);
    add_checked(1, 1, 0, est_pkg::MODE_STOPPED, 0, 0, 0, 1);
    add_sample(0, 0, 1);
    add_sample(0, 0, 0);
    add_sample(1, 1, 1);
    add_sample(1, 1, 0);
    add_sample(0, 0, 1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle();
        write_reg(script[i].idx, script[i].value);
      end else begin
        send_sample(script[i].s, script[i].pinned, script[i].want);
      end
    end

    for (phase = 0; phase < 8; phase++) begin
      settle();
      gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 18;
      stall_cap = ($urandom_range(0, 3) == 0) ? 0 : 18;
      pick_settings(phase);
      play_random((phase == 2) ? 60 : 250);
    end

    settle();
    $display("%0d samples sent, %0d results checked, %0d register writes",
             samples_sent, results_seen, reg_writes);
    $display("%0d results flagged a change, %0d showed the finished state",
             change_words, finished_words);
    if (errors == 0)
      $display("encoder_set_countdown_timer_unit: match");
    else
      $display("encoder_set_countdown_timer_unit: mismatch");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("encoder_set_countdown_timer_unit: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/est_pkg.sv
rtl/est_in_stage.sv
rtl/est_out_stage.sv
rtl/est_core.sv
rtl/encoder_set_countdown_timer_unit.sv
rtl/est_checker.sv
tb/encoder_set_countdown_timer_unit_tb.sv
